// ===== hw/rtl/triangle_jacobian_from_edge_lengths_defines.svh =====
// Assertion macros for the triangle Jacobian block.
`ifndef TRIANGLE_JACOBIAN_FROM_EDGE_LENGTHS_DEFINES_SVH
`define TRIANGLE_JACOBIAN_FROM_EDGE_LENGTHS_DEFINES_SVH

`ifndef SYNTH
`define TJ_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tjac: implication check failed");
`define TJ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tjac: next-cycle check failed");
`else
`define TJ_ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define TJ_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== hw/rtl/tjac_pkg.sv =====
package tjac_pkg;

  localparam int LEN_W = 24;
  localparam int PT_W  = 24;
  localparam int E_W   = 25;
  localparam int SQ_W  = 48;
  localparam int K_W   = 50;
  localparam int KM_W  = 49;
  localparam int P_W   = 50;
  localparam int N_W   = 51;
  localparam int JAC_W = 32;
  localparam int QB_W  = 32;

  localparam logic [JAC_W-1:0] JAC_MAX = {1'b0, {(JAC_W-1){1'b1}}};
  localparam logic [JAC_W-1:0] JAC_MIN = {1'b1, {(JAC_W-1){1'b0}}};

  typedef struct packed {
    logic [LEN_W-1:0]        a;
    logic [LEN_W-1:0]        c;
    logic [SQ_W-1:0]         sq_c;
    logic                    kneg;
    logic signed [E_W-1:0]   e00;
    logic signed [E_W-1:0]   e01;
    logic signed [E_W-1:0]   e10;
    logic signed [E_W-1:0]   e11;
  } tdiv_side_t;

  typedef struct packed {
    logic [LEN_W-1:0]        a;
    logic signed [E_W-1:0]   e00;
    logic signed [E_W-1:0]   e10;
    logic                    deg;
    logic                    n0neg;
    logic [N_W-1:0]          n0mag;
    logic                    n1neg;
    logic [N_W-1:0]          n1mag;
  } root_side_t;

  typedef struct packed {
    logic neg;
    logic deg;
  } qdiv_side_t;

  function automatic logic [JAC_W-1:0] sat_jac(input logic neg, input logic ovf,
                                               input logic [QB_W-1:0] q);
    logic [JAC_W-1:0] res;
    if (neg) begin
      if (ovf || q[QB_W-1]) res = JAC_MIN;
      else res = JAC_W'(-q);
    end else begin
      if (ovf || q[QB_W-1]) res = JAC_MAX;
      else res = JAC_W'(q);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tjac_div.sv =====
module tjac_div #(
  parameter int NW = 49,
  parameter int DW = 25,
  parameter int QB = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QB-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int TW = NW - QB;
  localparam int MW = (TW > DW ? TW : DW) + 1;

  logic          vld  [QB+1];
  logic [DW-1:0] rem  [QB+1];
  logic [QB-1:0] low  [QB+1];
  logic [QB-1:0] quos [QB+1];
  logic [DW-1:0] dvs  [QB+1];
  logic          ovs  [QB+1];
  logic [SW-1:0] sds  [QB+1];
  logic [DW:0]   shf  [QB];
  logic          ge   [QB];
  logic          ovf0;

  always_comb begin
    ovf0 = MW'(num[NW-1:QB]) >= MW'(den);
    for (int j = 0; j < QB; j++) begin
      shf[j] = {rem[j], low[j][QB-1]};
      ge[j]  = shf[j] >= {1'b0, dvs[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QB; j++) vld[j] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int j = 0; j < QB; j++) vld[j+1] <= vld[j];
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= DW'(num[NW-1:QB]);
    low[0]  <= num[QB-1:0];
    quos[0] <= '0;
    dvs[0]  <= den;
    ovs[0]  <= ovf0;
    sds[0]  <= side_in;
    for (int j = 0; j < QB; j++) begin
      rem[j+1]  <= ge[j] ? DW'(shf[j] - {1'b0, dvs[j]}) : shf[j][DW-1:0];
      low[j+1]  <= low[j] << 1;
      quos[j+1] <= {quos[j][QB-2:0], ge[j]};
      dvs[j+1]  <= dvs[j];
      ovs[j+1]  <= ovs[j];
      sds[j+1]  <= sds[j];
    end
  end

  assign out_valid = vld[QB];
  assign quo       = quos[QB];
  assign ovf       = ovs[QB];
  assign side_out  = sds[QB];

endmodule

// ===== hw/rtl/tjac_sqrt.sv =====
module tjac_sqrt #(
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int RMW = RW + 1;

  logic            vld  [RW+1];
  logic [RMW-1:0]  rem  [RW+1];
  logic [RW-1:0]   rts  [RW+1];
  logic [2*RW-1:0] radl [RW+1];
  logic [SW-1:0]   sds  [RW+1];
  logic [RW+2:0]   shf  [RW];
  logic [RW+1:0]   trial[RW];
  logic            ge   [RW];

  always_comb begin
    for (int j = 0; j < RW; j++) begin
      shf[j]   = {rem[j], radl[j][2*RW-1 -: 2]};
      trial[j] = {rts[j], 2'b01};
      ge[j]    = shf[j] >= {1'b0, trial[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= RW; j++) vld[j] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int j = 0; j < RW; j++) vld[j+1] <= vld[j];
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= '0;
    rts[0]  <= '0;
    radl[0] <= rad;
    sds[0]  <= side_in;
    for (int j = 0; j < RW; j++) begin
      rem[j+1]  <= ge[j] ? RMW'(shf[j] - {1'b0, trial[j]}) : shf[j][RMW-1:0];
      rts[j+1]  <= {rts[j][RW-2:0], ge[j]};
      radl[j+1] <= radl[j] << 2;
      sds[j+1]  <= sds[j];
    end
  end

  assign out_valid = vld[RW];
  assign root      = rts[RW];
  assign side_out  = sds[RW];

endmodule

// ===== hw/rtl/triangle_jacobian_from_edge_lengths.sv =====
// channel  | signals                                        | handshake
// triangle | side_a..c, p1_u..p3_w                          | start & !busy
// jacobian | jac_00, jac_01, jac_10, jac_11, degenerate     | done, one cycle
//
// Fully pipelined: one triangle per cycle, busy is always low.
// Latency is the LATENCY parameter, set by the 24-step divide for t, the
// 24-step square root for h and the 32-step divides for the entries.
// Synchronous reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall; every result is shown on done for one cycle.
`include "triangle_jacobian_from_edge_lengths_defines.svh"

module triangle_jacobian_from_edge_lengths
  import tjac_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [LEN_W-1:0]        side_a,
  input  logic [LEN_W-1:0]        side_b,
  input  logic [LEN_W-1:0]        side_c,
  input  logic signed [PT_W-1:0]  p1_u,
  input  logic signed [PT_W-1:0]  p1_w,
  input  logic signed [PT_W-1:0]  p2_u,
  input  logic signed [PT_W-1:0]  p2_w,
  input  logic signed [PT_W-1:0]  p3_u,
  input  logic signed [PT_W-1:0]  p3_w,
  output logic                    done,
  output logic signed [JAC_W-1:0] jac_00,
  output logic signed [JAC_W-1:0] jac_01,
  output logic signed [JAC_W-1:0] jac_10,
  output logic signed [JAC_W-1:0] jac_11,
  output logic                    degenerate
);

  localparam int LATENCY = 3 + (LEN_W + 1) + 2 + (LEN_W + 1) + 1 + (QB_W + 1) + 1;
  localparam int R0_NW   = E_W + FRAC_BITS;
  localparam int R1_NW   = N_W + FRAC_BITS;

  logic                   v0, v1, v2, v3, v4, v5;
  logic [LEN_W-1:0]       a0, b0, c0;
  logic signed [PT_W-1:0] u1_0, w1_0, u2_0, w2_0, u3_0, w3_0;

  logic [SQ_W-1:0]        sq_a1, sq_b1, sq_c1;
  logic [LEN_W-1:0]       a1, c1;
  logic signed [E_W-1:0]  e00_1, e01_1, e10_1, e11_1;

  logic signed [K_W-1:0]  kval;
  logic [KM_W-1:0]        kmag2;
  logic [LEN_W:0]         den2;
  tdiv_side_t             tside2;

  logic                   t_vld, t_ovf;
  logic [LEN_W-1:0]       t_quo;
  tdiv_side_t             t_side;
  logic signed [E_W-1:0]  a_s, t_s;

  logic                   deg3;
  logic [SQ_W-1:0]        tsq3, sq_c3;
  logic [LEN_W-1:0]       a3;
  logic signed [E_W-1:0]  e00_3, e10_3;
  logic signed [P_W-1:0]  p01a3, p01b3, p11a3, p11b3;

  logic signed [N_W-1:0]  n0, n1;
  logic [SQ_W-1:0]        h2_4;
  root_side_t             rside4;

  logic                   r_vld;
  logic [LEN_W-1:0]       h_root;
  root_side_t             r_side;

  logic [SQ_W-1:0]        den_ah5;
  logic [LEN_W-1:0]       a5;
  logic [E_W-1:0]         m00_5, m10_5;
  logic [N_W-1:0]         n0mag5, n1mag5;
  qdiv_side_t             s00_5, s10_5, s01_5, s11_5;

  logic                   q_vld, q10_vld, q01_vld, q11_vld;
  logic [QB_W-1:0]        q00, q10, q01, q11;
  logic                   o00, o10, o01, o11;
  qdiv_side_t             qs00, qs10, qs01, qs11;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a0 <= side_a;
    b0 <= side_b;
    c0 <= side_c;
    u1_0 <= p1_u;
    w1_0 <= p1_w;
    u2_0 <= p2_u;
    w2_0 <= p2_w;
    u3_0 <= p3_u;
    w3_0 <= p3_w;
  end

  // Squares and edge matrix
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
  end

  always_ff @(posedge clk) begin
    sq_a1 <= SQ_W'(a0) * SQ_W'(a0);
    sq_b1 <= SQ_W'(b0) * SQ_W'(b0);
    sq_c1 <= SQ_W'(c0) * SQ_W'(c0);
    a1    <= a0;
    c1    <= c0;
    e00_1 <= E_W'(u3_0) - E_W'(u2_0);
    e01_1 <= E_W'(u1_0) - E_W'(u2_0);
    e10_1 <= E_W'(w3_0) - E_W'(w2_0);
    e11_1 <= E_W'(w1_0) - E_W'(w2_0);
  end

  // Law of cosines numerator
  assign kval = $signed(K_W'(sq_a1)) + $signed(K_W'(sq_c1)) - $signed(K_W'(sq_b1));

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    kmag2       <= KM_W'(kval[K_W-1] ? -kval : kval);
    den2        <= {a1, 1'b0};
    tside2.a    <= a1;
    tside2.c    <= c1;
    tside2.sq_c <= sq_c1;
    tside2.kneg <= kval[K_W-1];
    tside2.e00  <= e00_1;
    tside2.e01  <= e01_1;
    tside2.e10  <= e10_1;
    tside2.e11  <= e11_1;
  end

  tjac_div #(
    .NW(KM_W),
    .DW(LEN_W + 1),
    .QB(LEN_W),
    .SW($bits(tdiv_side_t))
  ) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .num      (kmag2),
    .den      (den2),
    .side_in  (tside2),
    .out_valid(t_vld),
    .quo      (t_quo),
    .ovf      (t_ovf),
    .side_out (t_side)
  );

  // Height squared products and Jacobian numerator products
  assign a_s = $signed({1'b0, t_side.a});
  assign t_s = t_side.kneg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= t_vld;
  end

  always_ff @(posedge clk) begin
    deg3  <= (t_side.a == '0) || t_ovf || (t_quo >= t_side.c);
    tsq3  <= SQ_W'(t_quo) * SQ_W'(t_quo);
    sq_c3 <= t_side.sq_c;
    a3    <= t_side.a;
    e00_3 <= t_side.e00;
    e10_3 <= t_side.e10;
    p01a3 <= t_side.e01 * a_s;
    p01b3 <= t_side.e00 * t_s;
    p11a3 <= t_side.e11 * a_s;
    p11b3 <= t_side.e10 * t_s;
  end

  assign n0 = N_W'(p01a3) - N_W'(p01b3);
  assign n1 = N_W'(p11a3) - N_W'(p11b3);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
  end

  always_ff @(posedge clk) begin
    h2_4         <= sq_c3 - tsq3;
    rside4.a     <= a3;
    rside4.e00   <= e00_3;
    rside4.e10   <= e10_3;
    rside4.deg   <= deg3;
    rside4.n0neg <= n0[N_W-1];
    rside4.n0mag <= n0[N_W-1] ? N_W'(-n0) : N_W'(n0);
    rside4.n1neg <= n1[N_W-1];
    rside4.n1mag <= n1[N_W-1] ? N_W'(-n1) : N_W'(n1);
  end

  tjac_sqrt #(
    .RW(LEN_W),
    .SW($bits(root_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .rad      (h2_4),
    .side_in  (rside4),
    .out_valid(r_vld),
    .root     (h_root),
    .side_out (r_side)
  );

  // Denominator and magnitudes
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= r_vld;
  end

  always_ff @(posedge clk) begin
    den_ah5   <= SQ_W'(r_side.a) * SQ_W'(h_root);
    a5        <= r_side.a;
    m00_5     <= r_side.e00[E_W-1] ? E_W'(-r_side.e00) : E_W'(r_side.e00);
    m10_5     <= r_side.e10[E_W-1] ? E_W'(-r_side.e10) : E_W'(r_side.e10);
    n0mag5    <= r_side.n0mag;
    n1mag5    <= r_side.n1mag;
    s00_5.neg <= r_side.e00[E_W-1];
    s00_5.deg <= r_side.deg;
    s10_5.neg <= r_side.e10[E_W-1];
    s10_5.deg <= r_side.deg;
    s01_5.neg <= r_side.n0neg;
    s01_5.deg <= r_side.deg;
    s11_5.neg <= r_side.n1neg;
    s11_5.deg <= r_side.deg;
  end

  tjac_div #(.NW(R0_NW), .DW(LEN_W), .QB(QB_W), .SW($bits(qdiv_side_t))) u_div00 (
    .clk(clk), .rst(rst), .in_valid(v5), .num({m00_5, {FRAC_BITS{1'b0}}}),
    .den(a5), .side_in(s00_5), .out_valid(q_vld), .quo(q00), .ovf(o00),
    .side_out(qs00)
  );

  tjac_div #(.NW(R0_NW), .DW(LEN_W), .QB(QB_W), .SW($bits(qdiv_side_t))) u_div10 (
    .clk(clk), .rst(rst), .in_valid(v5), .num({m10_5, {FRAC_BITS{1'b0}}}),
    .den(a5), .side_in(s10_5), .out_valid(q10_vld), .quo(q10), .ovf(o10),
    .side_out(qs10)
  );

  tjac_div #(.NW(R1_NW), .DW(SQ_W), .QB(QB_W), .SW($bits(qdiv_side_t))) u_div01 (
    .clk(clk), .rst(rst), .in_valid(v5), .num({n0mag5, {FRAC_BITS{1'b0}}}),
    .den(den_ah5), .side_in(s01_5), .out_valid(q01_vld), .quo(q01), .ovf(o01),
    .side_out(qs01)
  );

  tjac_div #(.NW(R1_NW), .DW(SQ_W), .QB(QB_W), .SW($bits(qdiv_side_t))) u_div11 (
    .clk(clk), .rst(rst), .in_valid(v5), .num({n1mag5, {FRAC_BITS{1'b0}}}),
    .den(den_ah5), .side_in(s11_5), .out_valid(q11_vld), .quo(q11), .ovf(o11),
    .side_out(qs11)
  );

  // Output register: sign, saturate, zero degenerate items
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      degenerate <= 1'b0;
    end else begin
      done       <= q_vld;
      degenerate <= q_vld && qs00.deg;
    end
  end

  always_ff @(posedge clk) begin
    jac_00 <= qs00.deg ? '0 : sat_jac(qs00.neg, o00, q00);
    jac_10 <= qs10.deg ? '0 : sat_jac(qs10.neg, o10, q10);
    jac_01 <= qs01.deg ? '0 : sat_jac(qs01.neg, o01, q01);
    jac_11 <= qs11.deg ? '0 : sat_jac(qs11.neg, o11, q11);
  end

  `TJ_ASSERT_IMPLIES(a_deg_zero, clk, rst, done && degenerate, jac_00 == '0 && jac_01 == '0 && jac_10 == '0 && jac_11 == '0)
  `TJ_ASSERT_IMPLIES(a_lanes_aligned, clk, rst, q_vld || q10_vld || q01_vld || q11_vld, q_vld && q10_vld && q01_vld && q11_vld)
  `TJ_ASSERT_IMPLIES(a_latency, clk, rst, done, $past(start && !busy, LATENCY))
  `TJ_ASSERT_NEXT(a_zero_base, clk, rst, t_vld && t_side.a == '0, v3 && deg3)

endmodule
